// ----- design/apre_pkg.sv -----
// Shared types and constants of the ARGB palette run-length encoder.
package apre_pkg;

   // Fixed field widths
   localparam int unsigned ARGB_W   = 16;
   localparam int unsigned COLOR_W  = 16;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned RUN_W    = 8;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned FRAME_W  = 32;

   // Match tree: 16 groups of 16 palette slots
   localparam int unsigned SLOT_COUNT  = 256;
   localparam int unsigned GROUP_SIZE  = 16;
   localparam int unsigned GROUP_COUNT = SLOT_COUNT / GROUP_SIZE;
   localparam int unsigned LOCAL_W     = 4;

   // Command queue between classifier and run coder
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

   // Request types
   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   // Result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_RUN   = 2'd0,
      KIND_ADDED = 2'd1,
      KIND_FULL  = 2'd2
   } apre_kind_type;

   // Classified command opcodes
   typedef enum logic [1:0] {
      OP_PIXEL = 2'd0,
      OP_CLEAR = 2'd1,
      OP_FULL  = 2'd2
   } apre_op_type;

   // Classifier states
   typedef enum logic [1:0] {
      FS_IDLE   = 2'd0,
      FS_MATCH  = 2'd1,
      FS_GROUP  = 2'd2,
      FS_DECIDE = 2'd3
   } apre_front_state_type;

   typedef struct packed {
      apre_op_type              op;
      logic                     added;
      logic [INDEX_W-1:0]       index;
      logic [COLOR_W-1:0]       color;
   } apre_cmd_type;

   typedef struct packed {
      apre_kind_type            kind;
      logic [RUN_W-1:0]         run_length;
      logic [INDEX_W-1:0]       pair_index;
      logic [COLOR_W-1:0]       new_color;
      logic                     frame_end;
      logic                     last;
   } apre_result_type;

   // ARGB4444 to RGB565: each nibble widened by 17, then truncated
   function automatic logic [COLOR_W-1:0] to_rgb565(input logic [ARGB_W-1:0] argb);
      logic [3:0] a;
      logic [3:0] r;
      logic [3:0] g;
      logic [3:0] b;
      a = argb[15:12];
      r = argb[11:8];
      g = argb[7:4];
      b = argb[3:0];
      if (a == 4'd0) begin
         return '0;
      end
      return {r, r[3], g, g[3:2], b, b[3]};
   endfunction

endpackage

// ----- design/apre_if.sv -----
// Request and response channel interfaces of the palette run-length encoder.
interface apre_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [apre_pkg::ARGB_W-1:0]  pixel_argb;

   modport source (output valid, output req_type, output pixel_argb, input ready);
   modport sink   (input valid, input req_type, input pixel_argb, output ready);
endinterface

interface apre_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [apre_pkg::KIND_W-1:0]   kind;
   logic [apre_pkg::RUN_W-1:0]    run_length;
   logic [apre_pkg::INDEX_W-1:0]  pair_index;
   logic [apre_pkg::COLOR_W-1:0]  new_color;
   logic                          frame_end;
   logic                          last;

   modport source (output valid, output kind, output run_length, output pair_index,
                   output new_color, output frame_end, output last, input ready);
   modport sink   (input valid, input kind, input run_length, input pair_index,
                   input new_color, input frame_end, input last, output ready);
endinterface

// ----- design/apre_front.sv -----
// Classifier: color conversion, palette match and append, palette-full tracking.
module apre_front #(
   parameter int unsigned PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   apre_req_if.sink              req_ch,
   input  logic                  q_full,
   output logic                  q_push,
   output apre_pkg::apre_cmd_type q_push_data
);

   localparam int unsigned FILL_W = $clog2(PALETTE_ENTRIES + 1);
   localparam int unsigned IDX_W  = $clog2(PALETTE_ENTRIES);

   apre_pkg::apre_front_state_type state_ff, state_in;

   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic                           failed_ff, failed_in;
   logic [apre_pkg::COLOR_W-1:0]   color_ff, color_in;

   logic [apre_pkg::COLOR_W-1:0]   store [PALETTE_ENTRIES];
   logic                           store_wr;

   logic [apre_pkg::SLOT_COUNT-1:0] hit_in, hit_ff;
   logic [apre_pkg::GROUP_COUNT-1:0] grp_any_in, grp_any_ff;
   logic [apre_pkg::LOCAL_W-1:0]   grp_loc_in [apre_pkg::GROUP_COUNT];
   logic [apre_pkg::LOCAL_W-1:0]   grp_loc_ff [apre_pkg::GROUP_COUNT];

   logic                           found;
   logic [apre_pkg::INDEX_W-1:0]   found_idx;
   logic                           accept;

   assign req_ch.ready = (state_ff == apre_pkg::FS_IDLE) && !q_full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Parallel compare against every live palette slot
   for (genvar i = 0; i < apre_pkg::SLOT_COUNT; i++) begin : g_hit
      if (i > 0 && i < PALETTE_ENTRIES) begin : g_live
         assign hit_in[i] = (FILL_W'(i) < fill_ff) && (color_ff != '0) &&
                            (store[i] == color_ff);
      end else begin : g_dead
         assign hit_in[i] = 1'b0;
      end
   end

   // Per-group encode; entries are unique so an OR picks the one hit
   always_comb begin
      for (int g = 0; g < apre_pkg::GROUP_COUNT; g++) begin
         grp_any_in[g] = 1'b0;
         grp_loc_in[g] = '0;
         for (int j = 0; j < apre_pkg::GROUP_SIZE; j++) begin
            if (hit_ff[g * apre_pkg::GROUP_SIZE + j]) begin
               grp_any_in[g] = 1'b1;
               grp_loc_in[g] = grp_loc_in[g] | apre_pkg::LOCAL_W'(j);
            end
         end
      end
   end

   // Final encode across groups
   always_comb begin
      found     = |grp_any_ff;
      found_idx = '0;
      for (int g = 0; g < apre_pkg::GROUP_COUNT; g++) begin
         if (grp_any_ff[g]) begin
            found_idx = found_idx | {apre_pkg::LOCAL_W'(g), grp_loc_ff[g]};
         end
      end
   end

   // Next state and queue push
   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      failed_in   = failed_ff;
      color_in    = color_ff;
      store_wr    = 1'b0;
      q_push      = 1'b0;
      q_push_data = '{op: apre_pkg::OP_PIXEL, added: 1'b0, index: '0, color: '0};

      unique case (state_ff)
         apre_pkg::FS_IDLE: begin
            if (accept) begin
               if (req_ch.req_type == apre_pkg::REQ_CLEAR) begin
                  q_push         = 1'b1;
                  q_push_data.op = apre_pkg::OP_CLEAR;
                  fill_in        = FILL_W'(1);
                  failed_in      = 1'b0;
               end else if (!failed_ff) begin
                  color_in = apre_pkg::to_rgb565(req_ch.pixel_argb);
                  state_in = apre_pkg::FS_MATCH;
               end
            end
         end
         apre_pkg::FS_MATCH: begin
            state_in = apre_pkg::FS_GROUP;
         end
         apre_pkg::FS_GROUP: begin
            state_in = apre_pkg::FS_DECIDE;
         end
         apre_pkg::FS_DECIDE: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = apre_pkg::FS_IDLE;
               if (color_ff == '0) begin
                  q_push_data.index = '0;
               end else if (found) begin
                  q_push_data.index = found_idx;
               end else if (fill_ff >= FILL_W'(PALETTE_ENTRIES)) begin
                  // palette full: report once, then drop pixels until clear
                  q_push_data.op = apre_pkg::OP_FULL;
                  failed_in      = 1'b1;
               end else begin
                  q_push_data.added = 1'b1;
                  q_push_data.index = apre_pkg::INDEX_W'(fill_ff);
                  q_push_data.color = color_ff;
                  store_wr          = 1'b1;
                  fill_in           = fill_ff + FILL_W'(1);
               end
            end
         end
         default: begin
            state_in = apre_pkg::FS_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= apre_pkg::FS_IDLE;
         fill_ff   <= FILL_W'(1);
         failed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         failed_ff <= failed_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      color_ff   <= color_in;
      hit_ff     <= hit_in;
      grp_any_ff <= grp_any_in;
      grp_loc_ff <= grp_loc_in;
   end

   // Palette store, written at the fill slot
   always_ff @(posedge clock) begin
      if (store_wr) begin
         store[fill_ff[IDX_W-1:0]] <= color_ff;
      end
   end

endmodule

// ----- design/apre_queue.sv -----
// Small command queue between the classifier and the run coder.
module apre_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  apre_pkg::apre_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output apre_pkg::apre_cmd_type pop_data,
   output logic                   empty
);

   apre_pkg::apre_cmd_type         mem [apre_pkg::QUEUE_DEPTH];
   logic [apre_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [apre_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [apre_pkg::QPTR_W:0]      count_ff, count_in;

   assign full     = (count_ff == (apre_pkg::QPTR_W + 1)'(apre_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + apre_pkg::QPTR_W'(1);
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + apre_pkg::QPTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
         count_in = count_ff + (apre_pkg::QPTR_W + 1)'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
         count_in = count_ff - (apre_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/apre_back.sv -----
// Run coder: open run, frame position and ordered delivery of results.
module apre_back #(
   parameter int unsigned MAX_RUN = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [apre_pkg::FRAME_W-1:0]  frame_pixels,
   input  logic                          q_empty,
   input  apre_pkg::apre_cmd_type        q_pop_data,
   output logic                          q_pop,
   apre_rsp_if.source                    rsp_ch
);

   logic [apre_pkg::RUN_W-1:0]     run_cnt_ff, run_cnt_in;
   logic [apre_pkg::INDEX_W-1:0]   run_idx_ff, run_idx_in;
   logic [apre_pkg::FRAME_W-1:0]   pos_ff, pos_in;

   apre_pkg::apre_result_type      pend_ff [3];
   apre_pkg::apre_result_type      pend_in [3];
   logic [2:0]                     pend_vld_ff, pend_vld_in;

   apre_pkg::apre_result_type      rsp_ff, rsp_in;
   logic                           rsp_vld_ff, rsp_vld_in;

   logic                           out_free;
   logic                           close_run;
   logic                           frame_done;
   logic [apre_pkg::RUN_W-1:0]     cnt_after;
   logic [apre_pkg::INDEX_W-1:0]   idx_after;
   logic [apre_pkg::FRAME_W-1:0]   pos_next;
   apre_pkg::apre_result_type      blank;

   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign q_pop    = !q_empty && (pend_vld_ff == '0);
   assign blank    = '{kind: apre_pkg::KIND_RUN, run_length: '0, pair_index: '0,
                       new_color: '0, frame_end: 1'b0, last: 1'b0};

   // Run and frame bookkeeping for the command at the queue head
   always_comb begin
      close_run  = (run_cnt_ff != '0) &&
                   ((q_pop_data.index != run_idx_ff) ||
                    (run_cnt_ff >= apre_pkg::RUN_W'(MAX_RUN)));
      if (close_run || run_cnt_ff == '0) begin
         cnt_after = apre_pkg::RUN_W'(1);
         idx_after = q_pop_data.index;
      end else begin
         cnt_after = run_cnt_ff + apre_pkg::RUN_W'(1);
         idx_after = run_idx_ff;
      end
      pos_next   = pos_ff + apre_pkg::FRAME_W'(1);
      // zero frame size stands for a full 2^32 pixel frame
      frame_done = (frame_pixels == '0) ? (pos_next == '0) : (pos_next >= frame_pixels);
   end

   // Result slots, output register and state update
   always_comb begin
      run_cnt_in  = run_cnt_ff;
      run_idx_in  = run_idx_ff;
      pos_in      = pos_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp_ch.ready;

      // move the oldest pending result into the output register
      if (out_free && pend_vld_ff != '0) begin
         priority if (pend_vld_ff[0]) begin
            rsp_in         = pend_ff[0];
            rsp_vld_in     = 1'b1;
            pend_vld_in[0] = 1'b0;
         end else if (pend_vld_ff[1]) begin
            rsp_in         = pend_ff[1];
            rsp_vld_in     = 1'b1;
            pend_vld_in[1] = 1'b0;
         end else if (pend_vld_ff[2]) begin
            rsp_in         = pend_ff[2];
            rsp_vld_in     = 1'b1;
            pend_vld_in[2] = 1'b0;
         end
      end

      // expand the next command into up to three results
      if (q_pop) begin
         pend_in[0] = blank;
         pend_in[1] = blank;
         pend_in[2] = blank;
         unique case (q_pop_data.op)
            apre_pkg::OP_CLEAR: begin
               run_cnt_in = '0;
               run_idx_in = '0;
               pos_in     = '0;
            end
            apre_pkg::OP_FULL: begin
               pend_in[0].kind = apre_pkg::KIND_FULL;
               pend_in[0].last = 1'b1;
               pend_vld_in[0]  = 1'b1;
            end
            apre_pkg::OP_PIXEL: begin
               // palette-added notice
               pend_in[0].kind       = apre_pkg::KIND_ADDED;
               pend_in[0].pair_index = q_pop_data.index;
               pend_in[0].new_color  = q_pop_data.color;
               pend_in[0].last       = !close_run && !frame_done;
               pend_vld_in[0]        = q_pop_data.added;
               // run closed by index change or full count
               pend_in[1].run_length = run_cnt_ff;
               pend_in[1].pair_index = run_idx_ff;
               pend_in[1].last       = !frame_done;
               pend_vld_in[1]        = close_run;
               // run closed by the end of the frame
               pend_in[2].run_length = cnt_after;
               pend_in[2].pair_index = idx_after;
               pend_in[2].frame_end  = 1'b1;
               pend_in[2].last       = 1'b1;
               pend_vld_in[2]        = frame_done;
               if (frame_done) begin
                  run_cnt_in = '0;
                  run_idx_in = '0;
                  pos_in     = '0;
               end else begin
                  run_cnt_in = cnt_after;
                  run_idx_in = idx_after;
                  pos_in     = pos_next;
               end
            end
            default: begin
               run_cnt_in = run_cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_cnt_ff  <= '0;
         run_idx_ff  <= '0;
         pos_ff      <= '0;
         pend_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         run_cnt_ff  <= run_cnt_in;
         run_idx_ff  <= run_idx_in;
         pos_ff      <= pos_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Response port
   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.kind       = rsp_ff.kind;
   assign rsp_ch.run_length = rsp_ff.run_length;
   assign rsp_ch.pair_index = rsp_ff.pair_index;
   assign rsp_ch.new_color  = rsp_ff.new_color;
   assign rsp_ch.frame_end  = rsp_ff.frame_end;
   assign rsp_ch.last       = rsp_ff.last;

endmodule

// ----- design/argb_palette_rle_encoder.sv -----
// Top level of the ARGB palette quantizer with byte run-length coding.
//
//   channel   direction  payload
//   req_ch    in         req_type, pixel_argb
//   rsp_ch    out        kind, run_length, pair_index, new_color, frame_end, last
//   csr_*     in         frame_pixels (write only)
//
// A pixel request passes the classifier in order: color conversion, palette
// compare, group encode, decide and append (held while the queue is full).
// The run coder pops a command only when no result of the last is pending.
// Reset is synchronous; the palette contents are not cleared, only its fill.
// The command queue lets the classifier run ahead while responses are stalled.
module argb_palette_rle_encoder #(
   parameter int unsigned PALETTE_ENTRIES = 256,
   parameter int unsigned MAX_RUN         = 255
) (
   input  logic                          clock,
   input  logic                          reset,
   apre_req_if.sink                      req_ch,
   apre_rsp_if.source                    rsp_ch,
   input  logic                          csr_wr_en,
   input  logic [apre_pkg::FRAME_W-1:0]  csr_wr_data
);

   logic [apre_pkg::FRAME_W-1:0]  frame_pixels_ff;
   logic                          q_push;
   logic                          q_full;
   logic                          q_pop;
   logic                          q_empty;
   apre_pkg::apre_cmd_type        q_push_data;
   apre_pkg::apre_cmd_type        q_pop_data;

   // Frame size register
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pixels_ff <= apre_pkg::FRAME_W'(1);
      end else if (csr_wr_en) begin
         frame_pixels_ff <= csr_wr_data;
      end
   end

   apre_front #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_push_data (q_push_data)
   );

   apre_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   apre_back #(
      .MAX_RUN (MAX_RUN)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .frame_pixels (frame_pixels_ff),
      .q_empty      (q_empty),
      .q_pop_data   (q_pop_data),
      .q_pop        (q_pop),
      .rsp_ch       (rsp_ch)
   );

endmodule
